### hw/rtl/hpq_pkg.sv
package hpq_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int KEY_W        = 32;
    localparam int COUNT_OUT_W  = 8;
    localparam int S_TDATA_W    = 32;
    localparam int S_TUSER_W    = 1;
    // status, max_value, max_valid, entry_count, padded to whole bytes
    localparam int M_TDATA_W    = 48;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_RESP
    } state_t;

endpackage

### hw/rtl/max_heap_priority_queue_unit.sv
// bounded binary max-heap, one request at a time through a single compare unit
// insert: the key climbs level by level (parent read, then compare) until it is not larger or is at the root;
// delete-max: the last entry moves to the root and sinks (left child read, right child read, compare);
// a delete that empties the heap skips the sift, and a refused request goes straight to the response
// s_tready rises with the result; a new result waits while the previous one is held by m_tready low
// synchronous active-low reset empties the heap (count cleared), memory is not cleared
module max_heap_priority_queue_unit #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // value[31:0]
    input  logic [hpq_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [hpq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], max_value[33:2], max_valid[34], entry_count[42:35], zero pad
    output logic [hpq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [hpq_pkg::KEY_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [hpq_pkg::KEY_W-1:0] rd_data;

    hpq_ctrl #(
        .CAPACITY(CAPACITY),
        .AW      (AW),
        .CW      (CW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hpq_store #(
        .CAPACITY(CAPACITY),
        .AW      (AW)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

endmodule

### hw/rtl/hpq_store.sv
module hpq_store #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [hpq_pkg::KEY_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [hpq_pkg::KEY_W-1:0] rd_data
);

    logic [hpq_pkg::KEY_W-1:0] mem [CAPACITY];
    logic [hpq_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/hpq_ctrl.sv
module hpq_ctrl #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hpq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [hpq_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hpq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [hpq_pkg::KEY_W-1:0]     wr_data,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [hpq_pkg::KEY_W-1:0]     rd_data
);

    localparam int IW = AW + 2;

    hpq_pkg::state_t            state_reg, state_next;
    hpq_pkg::status_t           status_reg, status_next;
    logic [hpq_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [hpq_pkg::KEY_W-1:0]  bestv_reg, bestv_next;
    logic [hpq_pkg::KEY_W-1:0]  root_reg, root_next;
    logic                       left_reg, left_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       m_valid_reg, m_valid_next;
    logic [hpq_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [hpq_pkg::KEY_W-1:0]  cmp_a, cmp_b;
    logic                       cmp_gt;
    logic [IW-1:0]              count_ext, l_idx, r_idx;
    logic [AW-1:0]              parent;
    logic [CW+hpq_pkg::COUNT_OUT_W-1:0] count_wide;
    logic [hpq_pkg::KEY_W-1:0]  max_out;
    logic                       accept;

    assign count_ext  = {{(IW-CW){1'b0}}, count_reg};
    assign l_idx      = {1'b0, pos_reg, 1'b1};
    assign r_idx      = l_idx + IW'(1);
    assign parent     = AW'((pos_reg - AW'(1)) >> 1);
    assign count_wide = {{hpq_pkg::COUNT_OUT_W{1'b0}}, count_reg};
    assign max_out    = (count_reg != '0) ? root_reg : '0;
    assign s_tready   = (state_reg == hpq_pkg::S_IDLE);
    assign accept     = s_tvalid && s_tready;

    // the one comparator, operands picked by the sequencer state
    always_comb begin
        case (state_reg)
            hpq_pkg::S_UP_CMP: begin
                cmp_a = key_reg;
                cmp_b = rd_data;
            end
            hpq_pkg::S_DN_CMP: begin
                cmp_a = rd_data;
                cmp_b = bestv_reg;
            end
            default: begin
                cmp_a = rd_data;
                cmp_b = key_reg;
            end
        endcase
    end

    assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hpq_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        key_reg    <= key_next;
        bestv_reg  <= bestv_next;
        root_reg   <= root_next;
        left_reg   <= left_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        key_next     = key_reg;
        bestv_next   = bestv_reg;
        left_next    = left_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = key_reg;
        rd_en        = 1'b0;
        rd_addr      = parent;

        case (state_reg)
            hpq_pkg::S_IDLE: begin
                if (accept) begin
                    status_next = hpq_pkg::ST_DONE;
                    if (hpq_pkg::op_t'(s_tuser[0]) == hpq_pkg::OP_INSERT) begin
                        if (count_reg >= CW'(CAPACITY)) begin
                            status_next = hpq_pkg::ST_FULL;
                            state_next  = hpq_pkg::S_RESP;
                        end else begin
                            key_next   = s_tdata;
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = hpq_pkg::S_UP_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = hpq_pkg::ST_EMPTY;
                            state_next  = hpq_pkg::S_RESP;
                        end else begin
                            // fetch the last entry, it becomes the new root
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            count_next = count_reg - CW'(1);
                            state_next = hpq_pkg::S_DN_LOAD;
                        end
                    end
                end
            end
            hpq_pkg::S_UP_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    state_next = hpq_pkg::S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    state_next = hpq_pkg::S_UP_CMP;
                end
            end
            hpq_pkg::S_UP_CMP: begin
                wr_en = 1'b1;
                if (cmp_gt) begin
                    // parent moves down into the hole
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = hpq_pkg::S_UP_RD;
                end else begin
                    state_next = hpq_pkg::S_RESP;
                end
            end
            hpq_pkg::S_DN_LOAD: begin
                key_next = rd_data;
                pos_next = '0;
                if (count_reg == '0) begin
                    state_next = hpq_pkg::S_RESP;
                end else begin
                    state_next = hpq_pkg::S_DN_RDL;
                end
            end
            hpq_pkg::S_DN_RDL: begin
                if (l_idx >= count_ext) begin
                    wr_en      = 1'b1;
                    state_next = hpq_pkg::S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = l_idx[AW-1:0];
                    state_next = hpq_pkg::S_DN_RDR;
                end
            end
            hpq_pkg::S_DN_RDR: begin
                left_next  = cmp_gt;
                bestv_next = cmp_gt ? rd_data : key_reg;
                if (r_idx < count_ext) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                end
                state_next = hpq_pkg::S_DN_CMP;
            end
            hpq_pkg::S_DN_CMP: begin
                wr_en = 1'b1;
                if ((r_idx < count_ext) && cmp_gt) begin
                    wr_data    = rd_data;
                    pos_next   = r_idx[AW-1:0];
                    state_next = hpq_pkg::S_DN_RDL;
                end else if (left_reg) begin
                    wr_data    = bestv_reg;
                    pos_next   = l_idx[AW-1:0];
                    state_next = hpq_pkg::S_DN_RDL;
                end else begin
                    state_next = hpq_pkg::S_RESP;
                end
            end
            hpq_pkg::S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0,
                                    count_wide[hpq_pkg::COUNT_OUT_W-1:0],
                                    (count_reg != '0),
                                    max_out,
                                    status_reg};
                    state_next   = hpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = hpq_pkg::S_IDLE;
            end
        endcase
    end

    // shadow copy of the root for the result
    always_comb begin
        root_next = root_reg;
        if (wr_en && (wr_addr == '0)) begin
            root_next = wr_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hw/rtl/hpq_checker.sv
module hpq_checker #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hpq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [hpq_pkg::COUNT_OUT_W-1:0] CAP_CNT =
        hpq_pkg::COUNT_OUT_W'(CAPACITY);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // refused delete only on an empty heap
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == hpq_pkg::ST_EMPTY) |->
        !m_tdata[34] && (m_tdata[42:35] == '0) && (m_tdata[33:2] == '0))
        else $error("refused delete on non-empty heap");

    // refused insert only on a full heap
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == hpq_pkg::ST_FULL) |->
        m_tdata[34] && (m_tdata[42:35] == CAP_CNT))
        else $error("refused insert on non-full heap");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (CAPACITY < 256) |-> (m_tdata[34] == (m_tdata[42:35] != '0)))
        else $error("max_valid disagrees with entry_count");

endmodule

bind max_heap_priority_queue_unit hpq_checker #(
    .CAPACITY(CAPACITY)
) u_hpq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

### verif/heap_checker.sv
module heap_checker #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // value[31:0]
    input  logic [hpq_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [hpq_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], max_value[33:2], max_valid[34], entry_count[42:35], zero pad
    input  logic [hpq_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending
);
    import hpq_pkg::*;

    typedef struct {
        status_t          status;
        logic [KEY_W-1:0] max_value;
        logic             max_valid;
        logic [7:0]       entry_count;
    } heap_result_t;

    logic [KEY_W-1:0] heap_keys [CAPACITY];
    int               heap_fill;
    heap_result_t     expected_results [$];
    int               result_index;

    // updates the shadow heap and returns what the block should report
    function automatic heap_result_t apply_request(op_t op, logic [KEY_W-1:0] key);
        heap_result_t     r;
        int               pos;
        int               up;
        int               best;
        int               l;
        logic             settled;
        logic [KEY_W-1:0] tmp;
        r.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = heap_fill;
                heap_fill++;
                settled = 1'b0;
                while (pos > 0 && !settled) begin
                    up = (pos - 1) / 2;
                    if ($signed(key) > $signed(heap_keys[up])) begin
                        heap_keys[pos] = heap_keys[up];
                        pos = up;
                    end else begin
                        settled = 1'b1;
                    end
                end
                heap_keys[pos] = key;
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                heap_keys[0] = heap_keys[heap_fill-1];
                heap_fill--;
                pos = 0;
                settled = 1'b0;
                while (!settled) begin
                    best = pos;
                    l = 2 * pos + 1;
                    // left child wins a tie since the right must be strictly larger
                    if (l < heap_fill && $signed(heap_keys[l]) > $signed(heap_keys[best]))
                        best = l;
                    if (l + 1 < heap_fill
                        && $signed(heap_keys[l+1]) > $signed(heap_keys[best]))
                        best = l + 1;
                    if (best == pos) begin
                        settled = 1'b1;
                    end else begin
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[best];
                        heap_keys[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        r.max_valid = (heap_fill > 0);
        r.max_value = (heap_fill > 0) ? heap_keys[0] : '0;
        r.entry_count = heap_fill[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("result %0d: %s is %0h, expected %0h", result_index, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        heap_result_t want;
        if (!aresetn) begin
            heap_fill = 0;
            expected_results.delete();
            fail_count = 0;
            result_index = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(op_t'(s_tuser[0]), s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, tdata", 64'(m_tdata), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", 64'(m_tdata[1:0]), 64'(want.status));
                    if (m_tdata[33:2] != want.max_value)
                        report_mismatch("max_value", 64'(m_tdata[33:2]),
                                        64'(want.max_value));
                    if (m_tdata[34] != want.max_valid)
                        report_mismatch("max_valid", 64'(m_tdata[34]), 64'(want.max_valid));
                    if (m_tdata[42:35] != want.entry_count)
                        report_mismatch("entry_count", 64'(m_tdata[42:35]),
                                        64'(want.entry_count));
                end
                result_index++;
            end
        end
        pending = expected_results.size();
    end

endmodule

### verif/tb_max_heap_priority_queue_unit.sv
module tb_max_heap_priority_queue_unit;
    import hpq_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_CYCLES     = 400;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    fail_count;
    int                    pending;
    int                    results_seen;
    int                    idle_cycles;
    logic                  sender_burst;

    max_heap_priority_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    heap_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            // narrow range so equal keys show up often
            1, 2, 3: return 32'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(op_t op, logic [KEY_W-1:0] key, int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata = $urandom;
            s_tuser = 1'($urandom_range(0, 1));
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = key;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic int next_gap();
        if (sender_burst || $urandom_range(0, 2) == 0)
            return 0;
        return pick_gap();
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            results_seen <= 0;
        end else if (m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
        end
    end

    // counts cycles in which neither a request nor a result is transferred
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, steady stretches and one long hold-off
    initial begin
        int   stall_left;
        int   steady_left;
        int   hold_left;
        logic held_once;
        stall_left = 0;
        steady_left = 0;
        hold_left = 0;
        held_once = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (!held_once && results_seen >= 250) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready = 1'b0;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (steady_left > 0) begin
                m_tready = 1'b1;
                steady_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) == 0)
                    steady_left = $urandom_range(50, 200);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        int   sent;
        int   mode;
        int   run_len;
        int   insert_pct;
        op_t  op;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        sender_burst = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty refusal, key extremes, equal keys, drain past empty
        send_request(OP_DELETE, 32'h1234_5678, 1);
        send_request(OP_INSERT, 32'h8000_0000, 0);
        send_request(OP_INSERT, 32'h7fff_ffff, 0);
        send_request(OP_INSERT, 32'h0000_0000, 2);
        send_request(OP_INSERT, 32'hffff_ffff, 0);
        send_request(OP_INSERT, 32'd5, 0);
        send_request(OP_INSERT, 32'd5, 0);
        send_request(OP_INSERT, 32'd5, 3);
        send_request(OP_INSERT, 32'h8000_0000, 0);
        repeat (9) send_request(OP_DELETE, $urandom, 0);
        send_request(OP_DELETE, 32'hffff_ffff, 0);
        send_request(OP_INSERT, 32'h0000_0001, 1);
        send_request(OP_DELETE, 32'h0, 0);

        // random: fill runs hit full refusals, drain runs hit empty refusals
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            mode = $urandom_range(0, 2);
            sender_burst = ($urandom_range(0, 3) == 0);
            case (mode)
                0: begin
                    insert_pct = 90;
                    run_len = $urandom_range(60, 220);
                end
                1: begin
                    insert_pct = 10;
                    run_len = $urandom_range(60, 220);
                end
                default: begin
                    insert_pct = 50;
                    run_len = $urandom_range(20, 100);
                end
            endcase
            if (run_len > RANDOM_REQUESTS - sent)
                run_len = RANDOM_REQUESTS - sent;
            repeat (run_len) begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
                send_request(op, pick_key(), next_gap());
                sent++;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
